@@ design/vectored_interrupt_controller_unit_defines.svh @@
`ifndef VECTORED_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH
`define VECTORED_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH

// Check that holds in the same cycle.
`define VICU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define VICU_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

@@ design/vicu_pkg.sv @@
package vicu_pkg;

  localparam int unsigned PriW = 5;
  localparam logic [PriW-1:0] PriNonvec  = 5'd16;
  localparam logic [PriW-1:0] PriChained = 5'd17;
  localparam logic [PriW-1:0] PriNothing = 5'd18;
  localparam int unsigned StackDepth = 19;
  localparam logic [PriW-1:0] SpMax = 5'(StackDepth - 1);
  localparam logic [4:0] IdMask = 5'h1F;
  localparam int unsigned CntlEnableBit = 5;

  localparam logic [11:0] OffIrqStatus   = 12'h000;
  localparam logic [11:0] OffFiqStatus   = 12'h004;
  localparam logic [11:0] OffRawIntr     = 12'h008;
  localparam logic [11:0] OffIntSelect   = 12'h00C;
  localparam logic [11:0] OffIntEnable   = 12'h010;
  localparam logic [11:0] OffIntEnClear  = 12'h014;
  localparam logic [11:0] OffSoftInt     = 12'h018;
  localparam logic [11:0] OffSoftIntClr  = 12'h01C;
  localparam logic [11:0] OffProtection  = 12'h020;
  localparam logic [11:0] OffVectAddr    = 12'h030;
  localparam logic [11:0] OffDefVectAddr = 12'h034;
  localparam logic [11:0] OffSlotVecBase = 12'h100;
  localparam logic [11:0] OffSlotCtlBase = 12'h200;
  localparam logic [11:0] OffItcr        = 12'h300;

  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_LINE      = 3'd2,
    CMD_CHAIN_IRQ = 3'd3,
    CMD_CHAIN_FIQ = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_DENIED  = 2'd1,
    STAT_ERROR   = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  typedef enum logic {
    CFG_STRICT_MODE       = 1'b0,
    CFG_PROTECT_SUPPORTED = 1'b1
  } cfg_idx_e;

endpackage

@@ design/vicu_in_if.sv @@
interface vicu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [11:0] offset;
  logic [31:0] wdata;
  logic [4:0]  source_index;
  logic        level;
  logic [31:0] vector_in;
  logic        user_access;

  modport source (output valid, cmd, offset, wdata, source_index, level, vector_in, user_access,
                  input ready);
  modport sink (input valid, cmd, offset, wdata, source_index, level, vector_in, user_access,
                output ready);
endinterface

@@ design/vicu_out_if.sv @@
interface vicu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rdata;
  logic        irq_out;
  logic        fiq_out;
  logic [31:0] vector_out;
  logic [1:0]  status;

  modport source (output valid, rdata, irq_out, fiq_out, vector_out, status, input ready);
  modport sink (input valid, rdata, irq_out, fiq_out, vector_out, status, output ready);
endinterface

@@ design/vectored_interrupt_controller_unit.sv @@
// Vectored interrupt controller, 32 sources, 16 vector slots, PL190 register map.
// One item (bus read, bus write, source line change, chained IRQ or FIQ change)
// is taken at a time. After acceptance the item passes through decode and register
// update (S_EXEC), the priority scan (S_SCAN), settling of the request levels (S_FIN)
// and loading of the output register (S_OUT). The scan visits no slot when the item
// does not touch the IRQ priority logic; otherwise the single slot compare unit visits
// the vector slots, one per cycle, until it finds a hit or reaches the last slot.
// The block is ready again the cycle after the result is loaded.
// The result is held in the output register until taken; a result that is still
// waiting stalls the next one in its last step.
`include "vectored_interrupt_controller_unit_defines.svh"

module vectored_interrupt_controller_unit #(
  parameter int unsigned NUM_SLOTS   = 16,
  parameter int unsigned NUM_SOURCES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i,
  vicu_in_if.sink     in_ch,
  vicu_out_if.source  out_ch
);

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [31:0] SrcMask = 32'hFFFF_FFFF >> (32 - NUM_SOURCES);
  localparam logic [11:0] VecLast = 12'(vicu_pkg::OffSlotVecBase + 4 * (NUM_SLOTS - 1));
  localparam logic [11:0] CtlLast = 12'(vicu_pkg::OffSlotCtlBase + 4 * (NUM_SLOTS - 1));
  localparam logic [SlotW-1:0] SlotLast = SlotW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_FIN, S_OUT
  } state_e;

  state_e state_q;

  logic strict_q, psup_q;
  logic [31:0] lines_q, soft_q, sel_q, en_q, dv_q, cv_q, cvec_q;
  logic        prot_q, cirq_q, cfiq_q, irql_q, fiql_q;
  logic [4:0]  cp_q, sp_q, p_q;
  logic [31:0] svec_q [NUM_SLOTS];
  logic [4:0]  ssrc_q [NUM_SLOTS];
  logic        sen_q  [NUM_SLOTS];
  logic [4:0]  stack_q [vicu_pkg::StackDepth];

  logic [2:0]  cmd_q;
  logic [11:0] off_q;
  logic [31:0] d_q, vin_q, vec_q;
  logic [4:0]  src_q;
  logic        lvl_q, user_q, upd_irq_q, upd_fiq_q;
  logic [SlotW-1:0] idx_q;
  logic [31:0] rd_q;
  logic [1:0]  st_q;

  logic        out_valid_q, out_irq_q, out_fiq_q;
  logic [31:0] out_rdata_q, out_vec_q;
  logic [1:0]  out_st_q;

  logic [31:0] raw, irqb, fiqb;
  logic [4:0]  top;
  logic        denied, vhit, chit, in_vhit, scan_hit;
  logic [1:0]  misuse;
  logic [11:0] in_rel;

  logic [31:0] rd_d;
  logic [1:0]  st_d;
  logic        upd_irq_d, upd_fiq_d;

  assign raw    = (lines_q | soft_q) & SrcMask;
  assign irqb   = raw & en_q & ~sel_q;
  assign fiqb   = raw & en_q & sel_q;
  assign top    = stack_q[sp_q];
  assign denied = prot_q & psup_q & user_q;
  assign misuse = strict_q ? vicu_pkg::STAT_ERROR : vicu_pkg::STAT_IGNORED;
  assign vhit   = (off_q >= vicu_pkg::OffSlotVecBase) && (off_q <= VecLast);
  assign chit   = (off_q >= vicu_pkg::OffSlotCtlBase) && (off_q <= CtlLast);
  assign in_vhit = (in_ch.offset >= vicu_pkg::OffSlotVecBase) && (in_ch.offset <= VecLast);
  assign in_rel = in_vhit ? (in_ch.offset - vicu_pkg::OffSlotVecBase)
                          : (in_ch.offset - vicu_pkg::OffSlotCtlBase);
  assign scan_hit = sen_q[idx_q] & irqb[ssrc_q[idx_q]];

  assign in_ch.ready       = (state_q == S_IDLE);
  assign out_ch.valid      = out_valid_q;
  assign out_ch.rdata      = out_rdata_q;
  assign out_ch.irq_out    = out_irq_q;
  assign out_ch.fiq_out    = out_fiq_q;
  assign out_ch.vector_out = out_vec_q;
  assign out_ch.status     = out_st_q;

  always_comb begin
    rd_d      = '0;
    st_d      = vicu_pkg::STAT_OK;
    upd_irq_d = 1'b0;
    upd_fiq_d = 1'b0;
    case (cmd_q)
      vicu_pkg::CMD_READ: begin
        if (denied) begin
          st_d = vicu_pkg::STAT_DENIED;
        end else begin
          case (off_q)
            vicu_pkg::OffIrqStatus:   rd_d = irqb;
            vicu_pkg::OffFiqStatus:   rd_d = fiqb;
            vicu_pkg::OffRawIntr:     rd_d = raw;
            vicu_pkg::OffIntSelect:   rd_d = sel_q;
            vicu_pkg::OffIntEnable:   rd_d = en_q;
            vicu_pkg::OffIntEnClear,
            vicu_pkg::OffSoftIntClr:  st_d = vicu_pkg::STAT_IGNORED;
            vicu_pkg::OffSoftInt:     rd_d = soft_q;
            vicu_pkg::OffProtection:  rd_d = {31'd0, prot_q};
            vicu_pkg::OffVectAddr: begin
              if (cp_q >= top || sp_q >= vicu_pkg::SpMax) begin
                st_d = misuse;
              end else begin
                rd_d = cv_q;
                upd_irq_d = 1'b1;
              end
            end
            vicu_pkg::OffDefVectAddr: rd_d = dv_q;
            default: begin
              if (vhit) begin
                rd_d = svec_q[idx_q];
              end else if (chit) begin
                rd_d = 32'({sen_q[idx_q], ssrc_q[idx_q] & vicu_pkg::IdMask});
              end else begin
                st_d = vicu_pkg::STAT_ERROR;
              end
            end
          endcase
        end
      end
      vicu_pkg::CMD_WRITE: begin
        if (denied) begin
          st_d = vicu_pkg::STAT_DENIED;
        end else begin
          case (off_q)
            vicu_pkg::OffIrqStatus,
            vicu_pkg::OffFiqStatus: st_d = misuse;
            vicu_pkg::OffRawIntr:   st_d = vicu_pkg::STAT_ERROR;
            vicu_pkg::OffIntSelect,
            vicu_pkg::OffSoftInt,
            vicu_pkg::OffSoftIntClr: begin
              upd_irq_d = 1'b1;
              upd_fiq_d = 1'b1;
            end
            vicu_pkg::OffIntEnable,
            vicu_pkg::OffIntEnClear: begin
              upd_irq_d = |(raw & d_q);
              upd_fiq_d = |(raw & d_q);
            end
            vicu_pkg::OffProtection: begin
              if (!psup_q && d_q[0]) begin
                st_d = vicu_pkg::STAT_IGNORED;
              end
            end
            vicu_pkg::OffVectAddr: begin
              if (sp_q == 5'd0 || sp_q > vicu_pkg::SpMax) begin
                st_d = misuse;
              end else begin
                upd_irq_d = 1'b1;
              end
            end
            vicu_pkg::OffDefVectAddr: upd_irq_d = 1'b1;
            vicu_pkg::OffItcr: ;
            default: begin
              if (vhit || chit) begin
                upd_irq_d = 1'b1;
              end else begin
                st_d = vicu_pkg::STAT_ERROR;
              end
            end
          endcase
        end
      end
      vicu_pkg::CMD_LINE: begin
        if (32'(src_q) >= NUM_SOURCES) begin
          st_d = vicu_pkg::STAT_IGNORED;
        end else begin
          upd_fiq_d = en_q[src_q] & sel_q[src_q];
          upd_irq_d = en_q[src_q] & ~sel_q[src_q];
        end
      end
      vicu_pkg::CMD_CHAIN_IRQ: begin
        upd_irq_d = (lvl_q != cirq_q) || (vin_q != cvec_q);
      end
      vicu_pkg::CMD_CHAIN_FIQ: begin
        upd_fiq_d = (lvl_q != cfiq_q);
      end
      default: st_d = vicu_pkg::STAT_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      strict_q    <= 1'b1;
      psup_q      <= 1'b1;
      lines_q     <= '0;
      soft_q      <= '0;
      sel_q       <= '0;
      en_q        <= '0;
      dv_q        <= '0;
      cv_q        <= '0;
      cvec_q      <= '0;
      prot_q      <= 1'b0;
      cirq_q      <= 1'b0;
      cfiq_q      <= 1'b0;
      irql_q      <= 1'b0;
      fiql_q      <= 1'b0;
      cp_q        <= vicu_pkg::PriNothing;
      sp_q        <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        svec_q[i] <= '0;
        ssrc_q[i] <= '0;
        sen_q[i]  <= 1'b0;
      end
      for (int i = 0; i < vicu_pkg::StackDepth; i++) begin
        stack_q[i] <= (i == 0) ? vicu_pkg::PriNothing : '0;
      end
      upd_irq_q   <= 1'b0;
      upd_fiq_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vicu_pkg::CFG_STRICT_MODE:       strict_q <= cfg_wdata_i;
          vicu_pkg::CFG_PROTECT_SUPPORTED: psup_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ch.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_q   <= in_ch.cmd;
            off_q   <= in_ch.offset;
            d_q     <= in_ch.wdata;
            src_q   <= in_ch.source_index;
            lvl_q   <= in_ch.level;
            vin_q   <= in_ch.vector_in;
            user_q  <= in_ch.user_access;
            idx_q   <= in_rel[SlotW+1:2];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          rd_q      <= rd_d;
          st_q      <= st_d;
          upd_irq_q <= upd_irq_d;
          upd_fiq_q <= upd_fiq_d;
          if (st_d == vicu_pkg::STAT_OK) begin
            case (cmd_q)
              vicu_pkg::CMD_READ: begin
                if (upd_irq_d) begin
                  sp_q <= sp_q + 5'd1;
                  stack_q[sp_q + 5'd1] <= cp_q;
                end
              end
              vicu_pkg::CMD_WRITE: begin
                case (off_q)
                  vicu_pkg::OffIntSelect:   sel_q <= d_q & SrcMask;
                  vicu_pkg::OffIntEnable:   en_q <= (en_q | d_q) & SrcMask;
                  vicu_pkg::OffIntEnClear:  en_q <= en_q & ~d_q;
                  vicu_pkg::OffSoftInt:     soft_q <= (soft_q | d_q) & SrcMask;
                  vicu_pkg::OffSoftIntClr:  soft_q <= soft_q & ~d_q;
                  vicu_pkg::OffProtection: begin
                    if (psup_q) begin
                      prot_q <= d_q[0];
                    end
                  end
                  vicu_pkg::OffVectAddr:    sp_q <= sp_q - 5'd1;
                  vicu_pkg::OffDefVectAddr: dv_q <= d_q;
                  default: begin
                    if (vhit) begin
                      svec_q[idx_q] <= d_q;
                    end else if (chit) begin
                      ssrc_q[idx_q] <= d_q[4:0] & vicu_pkg::IdMask;
                      sen_q[idx_q]  <= d_q[vicu_pkg::CntlEnableBit];
                    end
                  end
                endcase
              end
              vicu_pkg::CMD_LINE: lines_q[src_q] <= lvl_q;
              vicu_pkg::CMD_CHAIN_IRQ: begin
                cirq_q <= lvl_q;
                cvec_q <= vin_q;
              end
              vicu_pkg::CMD_CHAIN_FIQ: cfiq_q <= lvl_q;
              default: ;
            endcase
          end
          idx_q   <= '0;
          p_q     <= vicu_pkg::PriNonvec;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (!upd_irq_q) begin
            state_q <= S_FIN;
          end else if (scan_hit) begin
            p_q     <= 5'(idx_q);
            vec_q   <= svec_q[idx_q];
            state_q <= S_FIN;
          end else if (idx_q == SlotLast) begin
            state_q <= S_FIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_FIN: begin
          if (upd_fiq_q) begin
            fiql_q <= (|fiqb) | cfiq_q;
          end
          if (upd_irq_q) begin
            if (|irqb) begin
              if (p_q >= top) begin
                irql_q <= 1'b0;
              end else begin
                cv_q   <= (p_q == vicu_pkg::PriNonvec) ? dv_q : vec_q;
                cp_q   <= p_q;
                irql_q <= 1'b1;
              end
            end else if (vicu_pkg::PriChained >= top) begin
              irql_q <= 1'b0;
            end else begin
              if (cirq_q) begin
                cv_q <= cvec_q;
                cp_q <= vicu_pkg::PriChained;
              end
              irql_q <= cirq_q;
            end
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            out_rdata_q <= (st_q == vicu_pkg::STAT_OK) ? rd_q : '0;
            out_irq_q   <= irql_q;
            out_fiq_q   <= fiql_q;
            out_vec_q   <= irql_q ? cv_q : '0;
            out_st_q    <= st_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `VICU_ASSERT(a_sp_range, sp_q <= vicu_pkg::SpMax, "stack pointer out of range")
  `VICU_ASSERT_NEXT(a_accept_exec, in_ch.valid && in_ch.ready, state_q == S_EXEC, "item not taken")
  `VICU_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ch.ready, out_valid_q, "result dropped")
  `VICU_ASSERT(a_top_nothing, stack_q[0] == vicu_pkg::PriNothing, "stack bottom lost")

endmodule
